[design/knca_pkg.sv]
package knca_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIM      = 16;
    localparam int MAX_POINTS   = 1024;

    localparam int K_W      = $clog2(MAX_CLUSTERS);
    localparam int D_W      = $clog2(MAX_DIM);
    localparam int P_W      = $clog2(MAX_POINTS);
    localparam int CADDR_W  = K_W + D_W;
    localparam int CDEPTH   = 1 << CADDR_W;
    localparam int ASSIGN_W = K_W + 1;
    localparam int COORD_W  = 16;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int DIST_W   = 36;
    localparam int POP_W    = 11;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int REQ_W    = 2;

    localparam logic [ASSIGN_W-1:0] UNASSIGNED = ASSIGN_W'(MAX_CLUSTERS);
    localparam logic [POP_W-1:0]    POP_MAX    = '1;

    localparam logic [REQ_W-1:0] REQ_CENTER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POINT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PASS   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION     = 1'd1;

    typedef struct packed {
        logic           vld;
        logic           first_d;
        logic           last_d;
        logic           last_k;
        logic [K_W-1:0] k;
    } t_tag;

endpackage

[design/knca_ram.sv]
module knca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/knca_dist.sv]
module knca_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  knca_pkg::t_tag                i_tag,
    input  logic [knca_pkg::COORD_W-1:0]  i_center,
    input  logic [knca_pkg::COORD_W-1:0]  i_point,
    output logic                          o_done,
    output logic [knca_pkg::K_W-1:0]      o_best_k,
    output logic [knca_pkg::DIST_W-1:0]   o_best_d
);
    import knca_pkg::*;

    t_tag               r_s1;
    t_tag               r_s2;
    logic [PROD_W-1:0]  r_prod;
    logic [DIST_W-1:0]  r_acc;
    logic [DIST_W-1:0]  r_best_d;
    logic [K_W-1:0]     r_best_k;

    logic [COORD_W:0]   diff;
    logic [COORD_W:0]   diff_abs;
    logic [COORD_W-1:0] mag;
    logic [PROD_W-1:0]  n_prod;
    logic [DIST_W-1:0]  sum;
    logic               better;

    always_comb begin
        diff     = {i_center[COORD_W-1], i_center} - {i_point[COORD_W-1], i_point};
        diff_abs = diff[COORD_W] ? (~diff + (COORD_W+1)'(1)) : diff;
        mag      = diff_abs[COORD_W-1:0];
        n_prod   = PROD_W'(mag) * PROD_W'(mag);
        sum      = (r_s2.first_d ? '0 : r_acc) + DIST_W'(r_prod);
        better   = (r_s2.k == '0) || (sum < r_best_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_tag;
            r_s2 <= r_s1;
        end
        r_prod <= n_prod;
        if (r_s2.vld) begin
            r_acc <= sum;
            if (r_s2.last_d && better) begin
                r_best_d <= sum;
                r_best_k <= r_s2.k;
            end
        end
    end

    assign o_done   = r_s2.vld && r_s2.last_d && r_s2.last_k;
    assign o_best_k = r_best_k;
    assign o_best_d = r_best_d;

endmodule

[design/kmeans_nearest_center_assign_unit.sv]
// Channel   Direction  Handshake                   Payload
// request   in         start high while busy low   i_req_type .. i_last_coord
// result    out        o_result_valid, one cycle   o_point_id .. o_cluster_population
// config    in         i_cfg_we, no wait           i_cfg_idx, i_cfg_data
//
// Centre, coordinate and new-pass requests leave busy low, but for the last coordinate of an in-range point.
// A last coordinate keeps busy high while the search runs, one centre-memory read per
// coordinate of each centre; the result is shown in the first cycle with busy low.
// After reset a clearing pass over all MAX_POINTS (1024) prior entries holds busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module kmeans_nearest_center_assign_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [knca_pkg::REQ_W-1:0]      i_req_type,
    input  logic [knca_pkg::K_W-1:0]        i_cluster_index,
    input  logic [knca_pkg::P_W-1:0]        i_point_index,
    input  logic [knca_pkg::D_W-1:0]        i_dim_index,
    input  logic signed [knca_pkg::COORD_W-1:0] i_coord_value,
    input  logic                            i_last_coord,
    input  logic                            i_cfg_we,
    input  logic [knca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [knca_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_result_valid,
    output logic [knca_pkg::P_W-1:0]        o_point_id,
    output logic [knca_pkg::K_W-1:0]        o_nearest_cluster,
    output logic [knca_pkg::DIST_W-1:0]     o_min_sq_distance,
    output logic                            o_changed,
    output logic                            o_any_change,
    output logic [knca_pkg::POP_W-1:0]      o_cluster_population
);
    import knca_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [P_W-1:0]   r_clr, n_clr;
    logic [CFG_W-1:0] r_cfg_k, r_cfg_d;
    logic [K_W-1:0]   r_kmax, n_kmax;
    logic [D_W-1:0]   r_dmax, n_dmax;
    logic [K_W-1:0]   r_k, n_k;
    logic [D_W-1:0]   r_d, n_d;
    logic [P_W-1:0]   r_pidx, n_pidx;
    logic             r_flag, n_flag;
    logic [POP_W-1:0] r_pop [MAX_CLUSTERS];

    logic             r_out_vld;
    logic [P_W-1:0]   r_out_pid;
    logic [K_W-1:0]   r_out_k;
    logic [DIST_W-1:0] r_out_d;
    logic             r_out_chg;
    logic             r_out_any;
    logic [POP_W-1:0] r_out_pop;

    logic              accept;
    logic              fin;
    logic              changed;
    logic [POP_W-1:0]  pop_new;
    logic [K_W-1:0]    kmax_cfg;
    logic [D_W-1:0]    dmax_cfg;
    t_tag              tag;
    logic [COORD_W-1:0] center_rd;
    logic [COORD_W-1:0] point_rd;
    logic [ASSIGN_W-1:0] prior_rd;
    logic               prior_we;
    logic [P_W-1:0]     prior_waddr;
    logic [ASSIGN_W-1:0] prior_wdata;
    logic               center_we;
    logic               point_we;
    logic               dist_done;
    logic [K_W-1:0]     best_k;
    logic [DIST_W-1:0]  best_d;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign fin    = (r_state == ST_FIN);

    assign kmax_cfg = (r_cfg_k == '0) ? '0 :
                      (32'(r_cfg_k) > MAX_CLUSTERS) ? K_W'(MAX_CLUSTERS - 1) :
                      K_W'(r_cfg_k - CFG_W'(1));
    assign dmax_cfg = (r_cfg_d == '0) ? '0 :
                      (32'(r_cfg_d) > MAX_DIM) ? D_W'(MAX_DIM - 1) :
                      D_W'(r_cfg_d - CFG_W'(1));

    assign center_we = accept && (i_req_type == REQ_CENTER)
                       && (32'(i_cluster_index) < MAX_CLUSTERS)
                       && (32'(i_dim_index) < MAX_DIM);
    assign point_we  = accept && (i_req_type == REQ_POINT) && (32'(i_dim_index) < MAX_DIM);

    assign tag.vld     = (r_state == ST_RUN);
    assign tag.first_d = (r_d == '0);
    assign tag.last_d  = (r_d == r_dmax);
    assign tag.last_k  = (r_k == r_kmax);
    assign tag.k       = r_k;

    assign prior_we    = (r_state == ST_CLEAR) || fin;
    assign prior_waddr = fin ? r_pidx : r_clr;
    assign prior_wdata = fin ? {1'b0, best_k} : UNASSIGNED;

    assign changed = (prior_rd != {1'b0, best_k});
    assign pop_new = (r_pop[best_k] == POP_MAX) ? r_pop[best_k]
                                                : r_pop[best_k] + POP_W'(1);

    knca_ram #(.WIDTH(COORD_W), .DEPTH(CDEPTH)) u_center_ram (
        .i_clk   (i_clk),
        .i_we    (center_we),
        .i_waddr ({i_cluster_index, i_dim_index}),
        .i_wdata (i_coord_value),
        .i_raddr ({r_k, r_d}),
        .o_rdata (center_rd)
    );

    knca_ram #(.WIDTH(COORD_W), .DEPTH(MAX_DIM)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (point_we),
        .i_waddr (i_dim_index),
        .i_wdata (i_coord_value),
        .i_raddr (r_d),
        .o_rdata (point_rd)
    );

    knca_ram #(.WIDTH(ASSIGN_W), .DEPTH(MAX_POINTS)) u_prior_ram (
        .i_clk   (i_clk),
        .i_we    (prior_we),
        .i_waddr (prior_waddr),
        .i_wdata (prior_wdata),
        .i_raddr (r_pidx),
        .o_rdata (prior_rd)
    );

    knca_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_center (center_rd),
        .i_point  (point_rd),
        .o_done   (dist_done),
        .o_best_k (best_k),
        .o_best_d (best_d)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_kmax  = r_kmax;
        n_dmax  = r_dmax;
        n_k     = r_k;
        n_d     = r_d;
        n_pidx  = r_pidx;
        n_flag  = r_flag;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + P_W'(1);
                if (32'(r_clr) == MAX_POINTS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_POINT: begin
                            if (i_last_coord && (32'(i_point_index) < MAX_POINTS)) begin
                                n_state = ST_RUN;
                                n_pidx  = i_point_index;
                                n_kmax  = kmax_cfg;
                                n_dmax  = dmax_cfg;
                                n_k     = '0;
                                n_d     = '0;
                            end
                        end
                        REQ_PASS: begin
                            n_flag = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (r_d == r_dmax) begin
                    n_d = '0;
                    if (r_k == r_kmax) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_k = r_k + K_W'(1);
                    end
                end else begin
                    n_d = r_d + D_W'(1);
                end
            end
            ST_WAIT: begin
                if (dist_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_flag  = r_flag | changed;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_cfg_k   <= CFG_W'(1);
            r_cfg_d   <= CFG_W'(1);
            r_flag    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                r_pop[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_flag    <= n_flag;
            r_out_vld <= fin;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CLUSTER_COUNT: r_cfg_k <= i_cfg_data;
                    CFG_DIMENSION:     r_cfg_d <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept && (i_req_type == REQ_PASS)) begin
                for (int i = 0; i < MAX_CLUSTERS; i++) begin
                    r_pop[i] <= '0;
                end
            end else if (fin) begin
                r_pop[best_k] <= pop_new;
            end
        end
        r_kmax <= n_kmax;
        r_dmax <= n_dmax;
        r_k    <= n_k;
        r_d    <= n_d;
        r_pidx <= n_pidx;
        if (fin) begin
            r_out_pid <= r_pidx;
            r_out_k   <= best_k;
            r_out_d   <= best_d;
            r_out_chg <= changed;
            r_out_any <= r_flag | changed;
            r_out_pop <= pop_new;
        end
    end

    assign o_result_valid       = r_out_vld;
    assign o_point_id           = r_out_pid;
    assign o_nearest_cluster    = r_out_k;
    assign o_min_sq_distance    = r_out_d;
    assign o_changed            = r_out_chg;
    assign o_any_change         = r_out_any;
    assign o_cluster_population = r_out_pop;

endmodule

[design/knca_chk.sv]
module knca_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [knca_pkg::REQ_W-1:0]      i_req_type,
    input logic                            i_last_coord,
    input logic                            o_result_valid,
    input logic                            o_changed,
    input logic                            o_any_change,
    input logic [knca_pkg::POP_W-1:0]      o_cluster_population
);
    import knca_pkg::*;

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a preceding busy period");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_last_coord_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_POINT) && i_last_coord) |=> busy)
        else $error("last coordinate request did not start a search");

    a_population_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_cluster_population != '0))
        else $error("chosen cluster reported with zero population");

    a_change_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_changed) |-> o_any_change)
        else $error("changed point without pass change flag");

endmodule

bind kmeans_nearest_center_assign_unit knca_chk u_knca_chk (.*);
